// ===== src/gwle_pkg.sv =====
// ----------------------------------------------------------------------------
// gwle_pkg
// Types, constants and helper functions for the Gaussian-weighted lines
// evaluator: payload structs, table sizes, saturation and the exp table.
// ----------------------------------------------------------------------------
package gwle_pkg;

   localparam int MAX_BASIS   = 16;
   localparam int MAX_DIMS    = 2;
   localparam int EXP_ENTRIES = 256;

   localparam int CEN_DEPTH = MAX_BASIS * MAX_DIMS;
   localparam int COV_DEPTH = CEN_DEPTH * MAX_DIMS;
   localparam int CEN_AW    = $clog2(CEN_DEPTH);
   localparam int COV_AW    = $clog2(COV_DEPTH);
   localparam int OFF_AW    = $clog2(MAX_BASIS);
   localparam int BAS_W     = OFF_AW;
   localparam int NB_W      = 5;
   localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int PIX_W     = $clog2(MAX_DIMS * MAX_DIMS);
   localparam int FET_W     = $clog2(MAX_DIMS * MAX_DIMS + 1);
   localparam int CNT_W     = $clog2(MAX_DIMS + 1);
   localparam int FET_LAST  = MAX_DIMS * MAX_DIMS;

   localparam int OPW       = 48;
   localparam int W_W       = 17;
   localparam int WSUM_W    = W_W + $clog2(MAX_BASIS + 1);
   localparam int NUM_W     = 63;
   localparam int EXP_IDX_W = $clog2(EXP_ENTRIES);

   localparam logic signed [OPW-1:0] QLIM    = OPW'(64'h0000_4000_0000_0000);
   localparam logic signed [OPW-1:0] S32_MAX = OPW'(64'h0000_0000_7FFF_FFFF);
   localparam logic signed [OPW-1:0] S32_MIN = -S32_MAX - OPW'(1);

   // Taylor terms of exp(-16/EXP_ENTRIES), scaled by 2^58
   localparam logic [63:0] TAY_00 = 64'd1 << 58;
   localparam logic [63:0] TAY_01 = (TAY_00 * 64'd16) / 64'(EXP_ENTRIES * 1);
   localparam logic [63:0] TAY_02 = (TAY_01 * 64'd16) / 64'(EXP_ENTRIES * 2);
   localparam logic [63:0] TAY_03 = (TAY_02 * 64'd16) / 64'(EXP_ENTRIES * 3);
   localparam logic [63:0] TAY_04 = (TAY_03 * 64'd16) / 64'(EXP_ENTRIES * 4);
   localparam logic [63:0] TAY_05 = (TAY_04 * 64'd16) / 64'(EXP_ENTRIES * 5);
   localparam logic [63:0] TAY_06 = (TAY_05 * 64'd16) / 64'(EXP_ENTRIES * 6);
   localparam logic [63:0] TAY_07 = (TAY_06 * 64'd16) / 64'(EXP_ENTRIES * 7);
   localparam logic [63:0] TAY_08 = (TAY_07 * 64'd16) / 64'(EXP_ENTRIES * 8);
   localparam logic [63:0] TAY_09 = (TAY_08 * 64'd16) / 64'(EXP_ENTRIES * 9);
   localparam logic [63:0] TAY_10 = (TAY_09 * 64'd16) / 64'(EXP_ENTRIES * 10);
   localparam logic [63:0] TAY_11 = (TAY_10 * 64'd16) / 64'(EXP_ENTRIES * 11);
   localparam logic [63:0] TAY_12 = (TAY_11 * 64'd16) / 64'(EXP_ENTRIES * 12);
   localparam logic [63:0] TAY_13 = (TAY_12 * 64'd16) / 64'(EXP_ENTRIES * 13);
   localparam logic [63:0] TAY_14 = (TAY_13 * 64'd16) / 64'(EXP_ENTRIES * 14);
   localparam logic [63:0] TAY_15 = (TAY_14 * 64'd16) / 64'(EXP_ENTRIES * 15);
   localparam logic [63:0] TAY_16 = (TAY_15 * 64'd16) / 64'(EXP_ENTRIES * 16);
   localparam logic [63:0] TAY_17 = (TAY_16 * 64'd16) / 64'(EXP_ENTRIES * 17);
   localparam logic [63:0] TAY_18 = (TAY_17 * 64'd16) / 64'(EXP_ENTRIES * 18);
   localparam logic [63:0] TAY_19 = (TAY_18 * 64'd16) / 64'(EXP_ENTRIES * 19);
   localparam logic [63:0] TAY_20 = (TAY_19 * 64'd16) / 64'(EXP_ENTRIES * 20);
   localparam logic [63:0] TAY_21 = (TAY_20 * 64'd16) / 64'(EXP_ENTRIES * 21);
   localparam logic [63:0] TAY_22 = (TAY_21 * 64'd16) / 64'(EXP_ENTRIES * 22);
   localparam logic [63:0] TAY_23 = (TAY_22 * 64'd16) / 64'(EXP_ENTRIES * 23);
   localparam logic [63:0] TAY_24 = (TAY_23 * 64'd16) / 64'(EXP_ENTRIES * 24);
   localparam logic [63:0] TAY_POS = TAY_00 + TAY_02 + TAY_04 + TAY_06 + TAY_08
                                   + TAY_10 + TAY_12 + TAY_14 + TAY_16 + TAY_18
                                   + TAY_20 + TAY_22 + TAY_24;
   localparam logic [63:0] TAY_NEG = TAY_01 + TAY_03 + TAY_05 + TAY_07 + TAY_09
                                   + TAY_11 + TAY_13 + TAY_15 + TAY_17 + TAY_19
                                   + TAY_21 + TAY_23;
   localparam logic [63:0] EXP_R30 = (TAY_POS - TAY_NEG) >> 28;

   typedef enum logic {
      MODE_LOAD   = 1'b0,
      MODE_SAMPLE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      RGN_CENTER = 2'd0,
      RGN_COV    = 2'd1,
      RGN_SLOPE  = 2'd2,
      RGN_OFFSET = 2'd3
   } region_type;

   typedef enum logic [1:0] {
      CSR_NORMALIZE = 2'd0,
      CSR_PIVOT     = 2'd1,
      CSR_BASIS     = 2'd2,
      CSR_DIMS      = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_QT,
      ST_QQ,
      ST_LINE,
      ST_PIV,
      ST_WACC,
      ST_FINISH,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               mode;
      logic [1:0]         region;
      logic [5:0]         entry_index;
      logic signed [31:0] word_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weighted_sum;
      logic               zero_sum;
   } rsp_type;

   typedef struct packed {
      logic               we;
      logic [1:0]         region;
      logic [5:0]         index;
      logic signed [31:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic [CEN_AW-1:0] cen_addr;
      logic [COV_AW-1:0] cov_addr;
      logic [CEN_AW-1:0] slope_addr;
      logic [OFF_AW-1:0] off_addr;
   } tbl_rd_type;

   typedef struct packed {
      logic signed [31:0] cen;
      logic signed [31:0] cov;
      logic signed [31:0] slope;
      logic signed [31:0] off;
   } tbl_data_type;

   typedef logic [W_W-1:0] exp_tab_type [EXP_ENTRIES];

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] e30;
      e30 = 64'd1 << 30;
      for (int k = 0; k < EXP_ENTRIES; k++) begin
         tab[k] = W_W'((e30 + 64'd8192) >> 14);
         e30    = (e30 * EXP_R30) >> 30;
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

   function automatic logic [OPW-1:0] mag_op(input logic signed [OPW-1:0] v);
      return v[OPW-1] ? OPW'(-v) : OPW'(v);
   endfunction

   // add or subtract, saturated to +-2^46
   function automatic logic signed [OPW-1:0] sat_add(input logic signed [OPW-1:0] a,
                                                     input logic signed [OPW-1:0] b,
                                                     input logic              sub);
      logic signed [OPW:0] s;
      s = sub ? ((OPW+1)'(a) - (OPW+1)'(b)) : ((OPW+1)'(a) + (OPW+1)'(b));
      if (s > (OPW+1)'(QLIM)) begin
         return QLIM;
      end
      if (s < -(OPW+1)'(QLIM)) begin
         return -QLIM;
      end
      return s[OPW-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [OPW-1:0] v);
      if (v > S32_MAX) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < S32_MIN) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== src/gwle_tables.sv =====
// ----------------------------------------------------------------------------
// gwle_tables
// Center, inverse covariance, slope and offset tables. One write port from
// load transfers, one registered read port per table.
// ----------------------------------------------------------------------------
module gwle_tables
   import gwle_pkg::*;
(
   input  logic         clock,
   input  tbl_wr_type   wr,
   input  tbl_rd_type   rd,
   output tbl_data_type rd_data
);

   logic signed [31:0] cen_mem   [CEN_DEPTH];
   logic signed [31:0] cov_mem   [COV_DEPTH];
   logic signed [31:0] slope_mem [CEN_DEPTH];
   logic signed [31:0] off_mem   [MAX_BASIS];

   tbl_data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         if (wr.region == RGN_CENTER && int'(wr.index) < CEN_DEPTH) begin
            cen_mem[wr.index[CEN_AW-1:0]] <= wr.data;
         end
         if (wr.region == RGN_COV && int'(wr.index) < COV_DEPTH) begin
            cov_mem[wr.index[COV_AW-1:0]] <= wr.data;
         end
         if (wr.region == RGN_SLOPE && int'(wr.index) < CEN_DEPTH) begin
            slope_mem[wr.index[CEN_AW-1:0]] <= wr.data;
         end
         if (wr.region == RGN_OFFSET && int'(wr.index) < MAX_BASIS) begin
            off_mem[wr.index[OFF_AW-1:0]] <= wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff.cen   <= cen_mem[rd.cen_addr];
      rd_data_ff.cov   <= cov_mem[rd.cov_addr];
      rd_data_ff.slope <= slope_mem[rd.slope_addr];
      rd_data_ff.off   <= off_mem[rd.off_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gwle_mul.sv =====
// ----------------------------------------------------------------------------
// gwle_mul
// Shared Q16.16 multiplier: magnitude product in 16-bit slices, one slice
// per cycle, truncated by 16 bits and saturated to +-2^46.
// ----------------------------------------------------------------------------
module gwle_mul
   import gwle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic signed [OPW-1:0] op_a,
   input  logic signed [OPW-1:0] op_b,
   output logic                  done,
   output logic signed [OPW-1:0] prod
);

   localparam int SL      = 16;
   localparam int STEPS   = OPW / SL;
   localparam int STEP_W  = $clog2(STEPS);
   localparam int ACC_W   = 2 * OPW;

   logic [OPW-1:0]    ua_ff, ub_ff;
   logic              neg_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [OPW+SL-1:0] pp;
   logic [ACC_W-1:0]  sh;
   logic [OPW-1:0]    pm;

   assign pp = ua_ff * ub_ff[OPW-1 -: SL];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         ua_ff  <= mag_op(op_a);
         ub_ff  <= mag_op(op_b);
         neg_ff <= op_a[OPW-1] ^ op_b[OPW-1];
         acc_ff <= '0;
         cnt_ff <= STEP_W'(STEPS - 1);
      end else if (busy_ff) begin
         acc_ff <= (acc_ff << SL) + ACC_W'(pp);
         ub_ff  <= ub_ff << SL;
         cnt_ff <= cnt_ff - STEP_W'(1);
      end
   end

   always_comb begin
      sh = acc_ff >> SL;
      pm = (sh > ACC_W'(QLIM)) ? OPW'(QLIM) : sh[OPW-1:0];
   end

   assign prod = neg_ff ? -$signed(pm) : $signed(pm);
   assign done = done_ff;

endmodule

// ===== src/gwle_div.sv =====
// ----------------------------------------------------------------------------
// gwle_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gwle_div
   import gwle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [NUM_W-1:0]  num,
   input  logic [WSUM_W-1:0] den,
   output logic              done,
   output logic [NUM_W-1:0]  quo
);

   localparam int CNT_DW = $clog2(NUM_W);

   logic [NUM_W-1:0]  quo_ff;
   logic [WSUM_W-1:0] rem_ff;
   logic [WSUM_W-1:0] den_ff;
   logic [CNT_DW-1:0] cnt_ff;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WSUM_W:0]   rem_sh;
   logic [WSUM_W:0]   rem_sub;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= CNT_DW'(NUM_W - 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sub[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         cnt_ff <= cnt_ff - CNT_DW'(1);
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== src/gaussian_weighted_lines_eval.sv =====
// ----------------------------------------------------------------------------
// gaussian_weighted_lines_eval
// Evaluates a sum of Gaussian-weighted local lines in Q16.16 over per-basis
// tables held in synchronous memories, with one shared multiplier.
//
//   channel   dir   ports                          transfer when
//   req       in    req_valid/req_stall/req_data   valid & !stall
//   rsp       out   rsp_valid/rsp_stall/rsp_data   valid & !stall
//   csr       in    csr_we/csr_index/csr_wdata     csr_we
//
// Load and non-final coordinate transfers complete in the idle state. A final coordinate
// runs every basis: a fetch from the table read ports, then d*d+2d(+d pivot)+1
// multiplies, then a divide when normalizing over more than one basis with a
// nonzero weight sum.
// Reset is synchronous and clears control state; tables are not cleared.
// req_stall is high while a sample is evaluated; a finished result waits in
// the output register and the next transfer is taken meanwhile.
// ----------------------------------------------------------------------------
module gaussian_weighted_lines_eval
   import gwle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata
);

   state_type state_ff, state_in;

   logic            norm_ff, pivot_ff;
   logic [NB_W-1:0] nbas_ff;
   logic [1:0]      ndim_ff;
   logic [NB_W-1:0] nb_eff;
   logic [CNT_W-1:0] nd_eff;

   logic signed [31:0] x_ff   [MAX_DIMS];
   logic signed [31:0] c_ff   [MAX_DIMS];
   logic signed [31:0] a_ff   [MAX_DIMS];
   logic signed [31:0] pm_ff  [MAX_DIMS*MAX_DIMS];
   logic signed [31:0] off_ff;

   logic [CNT_W-1:0] coord_ff;
   logic [CNT_W-1:0] cc_eff, cc_next;
   logic             coord_done;

   logic [BAS_W-1:0] b_ff;
   logic [DIM_W-1:0] r_ff, k_ff;
   logic [FET_W-1:0] j_ff;
   logic [FET_W-1:0] jm;

   logic signed [OPW-1:0] t_ff, q_ff, line_ff, line0_ff, acc_ff, res_ff;
   logic [WSUM_W-1:0]     wsum_ff;
   logic                  zero_ff;
   logic                  issued_ff, issued_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic req_fire, out_free;
   logic b_last, r_last, k_last, need_div;

   logic [DIM_W-1:0]      idx_sel;
   logic [PIX_W-1:0]      pix;
   logic signed [31:0]    x_sel, c_sel, a_sel, p_sel;
   logic signed [OPW-1:0] diff_sel;

   logic [OPW-1:0]       q_pos;
   logic [OPW+10:0]      qprod;
   logic [OPW+10:0]      qidx;
   logic [W_W-1:0]       w_val;

   logic                  mul_go, mul_done;
   logic signed [OPW-1:0] mul_a, mul_b, mul_p;

   logic              div_go, div_done;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [OPW-1:0]    acc_mag;
   logic [OPW-1:0]    qm;

   tbl_wr_type   tbl_wr;
   tbl_rd_type   tbl_rd;
   tbl_data_type tbl_q;

   // effective configuration
   always_comb begin
      if (nbas_ff == '0) begin
         nb_eff = NB_W'(1);
      end else if (int'(nbas_ff) > MAX_BASIS) begin
         nb_eff = NB_W'(MAX_BASIS);
      end else begin
         nb_eff = nbas_ff;
      end
      if (ndim_ff == '0) begin
         nd_eff = CNT_W'(1);
      end else if (int'(ndim_ff) > MAX_DIMS) begin
         nd_eff = CNT_W'(MAX_DIMS);
      end else begin
         nd_eff = CNT_W'(ndim_ff);
      end
   end

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cc_eff     = (int'(coord_ff) >= MAX_DIMS) ? CNT_W'(MAX_DIMS - 1) : coord_ff;
      cc_next    = cc_eff + CNT_W'(1);
      coord_done = cc_next >= nd_eff;
   end

   assign b_last   = NB_W'(b_ff) == (nb_eff - NB_W'(1));
   assign r_last   = CNT_W'(r_ff) == (nd_eff - CNT_W'(1));
   assign k_last   = CNT_W'(k_ff) == (nd_eff - CNT_W'(1));
   assign need_div = norm_ff && (nb_eff != NB_W'(1)) && (wsum_ff != '0);
   assign jm       = j_ff - FET_W'(1);

   // operand selection
   always_comb begin
      idx_sel  = (state_ff == ST_QT) ? k_ff : r_ff;
      pix      = PIX_W'(int'(r_ff) * MAX_DIMS + int'(k_ff));
      x_sel    = x_ff[idx_sel];
      c_sel    = c_ff[idx_sel];
      a_sel    = a_ff[idx_sel];
      p_sel    = pm_ff[pix];
      diff_sel = OPW'(x_sel) - OPW'(c_sel);
   end

   // activation lookup
   always_comb begin
      q_pos = q_ff[OPW-1] ? '0 : OPW'(q_ff);
      qprod = (OPW+11)'(q_pos) * (OPW+11)'(EXP_ENTRIES);
      qidx  = qprod >> 21;
      if (qidx >= (OPW+11)'(EXP_ENTRIES)) begin
         w_val = '0;
      end else begin
         w_val = EXP_TAB[qidx[EXP_IDX_W-1:0]];
      end
   end

   always_comb begin
      acc_mag = mag_op(acc_ff);
      div_num = NUM_W'(acc_mag) << 16;
      qm      = (div_quo > (NUM_W'(1) << 32)) ? (OPW'(1) << 32) : OPW'(div_quo);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.mode == MODE_SAMPLE && coord_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (int'(j_ff) == FET_LAST) begin
               state_in = ST_QT;
            end
         end
         ST_QT: begin
            if (mul_done && k_last) begin
               state_in = ST_QQ;
            end
         end
         ST_QQ: begin
            if (mul_done) begin
               state_in = r_last ? ST_LINE : ST_QT;
            end
         end
         ST_LINE: begin
            if (mul_done && r_last) begin
               state_in = pivot_ff ? ST_PIV : ST_WACC;
            end
         end
         ST_PIV: begin
            if (mul_done && r_last) begin
               state_in = ST_WACC;
            end
         end
         ST_WACC: begin
            if (mul_done) begin
               state_in = b_last ? ST_FINISH : ST_FETCH;
            end
         end
         ST_FINISH: begin
            state_in = need_div ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      mul_go    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_go    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_QT: begin
            mul_go = !issued_ff;
            mul_a  = OPW'(p_sel);
            mul_b  = diff_sel;
         end
         ST_QQ: begin
            mul_go = !issued_ff;
            mul_a  = diff_sel;
            mul_b  = t_ff;
         end
         ST_LINE: begin
            mul_go = !issued_ff;
            mul_a  = OPW'(a_sel);
            mul_b  = OPW'(x_sel);
         end
         ST_PIV: begin
            mul_go = !issued_ff;
            mul_a  = OPW'(a_sel);
            mul_b  = OPW'(c_sel);
         end
         ST_WACC: begin
            mul_go = !issued_ff;
            mul_a  = line_ff;
            mul_b  = $signed(OPW'(w_val));
         end
         ST_FINISH: begin
            div_go = need_div;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      tbl_wr.we     = req_fire && req_data.mode == MODE_LOAD;
      tbl_wr.region = req_data.region;
      tbl_wr.index  = req_data.entry_index;
      tbl_wr.data   = req_data.word_value;
      tbl_rd.cen_addr   = CEN_AW'(int'(b_ff) * MAX_DIMS + int'(j_ff));
      tbl_rd.slope_addr = CEN_AW'(int'(b_ff) * MAX_DIMS + int'(j_ff));
      tbl_rd.cov_addr   = COV_AW'(int'(b_ff) * MAX_DIMS * MAX_DIMS + int'(j_ff));
      tbl_rd.off_addr   = b_ff;
   end

   assign issued_in = mul_done ? 1'b0 : (mul_go ? 1'b1 : issued_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         coord_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         norm_ff      <= 1'b0;
         pivot_ff     <= 1'b0;
         nbas_ff      <= NB_W'(16);
         ndim_ff      <= 2'd1;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         if (req_fire && req_data.mode == MODE_SAMPLE) begin
            coord_ff <= coord_done ? '0 : cc_next;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_NORMALIZE: norm_ff  <= csr_wdata[0];
               CSR_PIVOT:     pivot_ff <= csr_wdata[0];
               CSR_BASIS:     nbas_ff  <= csr_wdata;
               CSR_DIMS:      ndim_ff  <= csr_wdata[1:0];
               default:       norm_ff  <= norm_ff;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff != ST_FETCH) begin
         j_ff <= '0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.mode == MODE_SAMPLE) begin
               x_ff[cc_eff[DIM_W-1:0]] <= req_data.word_value;
               b_ff    <= '0;
               acc_ff  <= '0;
               wsum_ff <= '0;
            end
         end
         ST_FETCH: begin
            j_ff <= j_ff + FET_W'(1);
            if (j_ff != '0) begin
               pm_ff[jm[PIX_W-1:0]] <= tbl_q.cov;
               if (int'(jm) < MAX_DIMS) begin
                  c_ff[jm[DIM_W-1:0]] <= tbl_q.cen;
                  a_ff[jm[DIM_W-1:0]] <= tbl_q.slope;
               end
               if (jm == '0) begin
                  off_ff <= tbl_q.off;
               end
            end
            r_ff <= '0;
            k_ff <= '0;
            t_ff <= '0;
            q_ff <= '0;
         end
         ST_QT: begin
            if (mul_done) begin
               t_ff <= sat_add(t_ff, mul_p, 1'b0);
               k_ff <= k_last ? '0 : k_ff + DIM_W'(1);
            end
         end
         ST_QQ: begin
            if (mul_done) begin
               q_ff <= sat_add(q_ff, mul_p, 1'b0);
               t_ff <= '0;
               if (r_last) begin
                  r_ff    <= '0;
                  line_ff <= OPW'(off_ff);
               end else begin
                  r_ff <= r_ff + DIM_W'(1);
               end
            end
         end
         ST_LINE: begin
            if (mul_done) begin
               line_ff <= sat_add(line_ff, mul_p, 1'b0);
               r_ff    <= r_last ? '0 : r_ff + DIM_W'(1);
            end
         end
         ST_PIV: begin
            if (mul_done) begin
               line_ff <= sat_add(line_ff, mul_p, 1'b1);
               r_ff    <= r_last ? '0 : r_ff + DIM_W'(1);
            end
         end
         ST_WACC: begin
            if (mul_done) begin
               acc_ff  <= sat_add(acc_ff, mul_p, 1'b0);
               wsum_ff <= wsum_ff + WSUM_W'(w_val);
               if (b_ff == '0) begin
                  line0_ff <= line_ff;
               end
               if (!b_last) begin
                  b_ff <= b_ff + BAS_W'(1);
               end
            end
         end
         ST_FINISH: begin
            zero_ff <= norm_ff && (nb_eff != NB_W'(1)) && (wsum_ff == '0);
            if (norm_ff && nb_eff == NB_W'(1)) begin
               res_ff <= line0_ff;
            end else if (norm_ff && wsum_ff == '0) begin
               res_ff <= '0;
            end else begin
               res_ff <= acc_ff;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_ff <= acc_ff[OPW-1] ? -$signed(qm) : $signed(qm);
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_ff.weighted_sum <= sat32(res_ff);
               rsp_data_ff.zero_sum     <= zero_ff;
            end
         end
         default: begin
            zero_ff <= zero_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gwle_tables u_tables (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (tbl_q)
   );

   gwle_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   gwle_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (wsum_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   ast_mul_issued: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> issued_ff)
      else $error("multiplier result without an issued operation");

   ast_basis_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (NB_W'(b_ff) < nb_eff))
      else $error("basis counter beyond basis count");

   ast_div_cond: assert property (@(posedge clock) disable iff (reset)
      div_go |-> (norm_ff && wsum_ff != '0))
      else $error("divide started without normalization or with zero sum");

   ast_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_sum) |-> (rsp_data.weighted_sum == 32'sd0))
      else $error("zero sum flag with nonzero result");

   ast_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("result left before output register was free");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for gaussian_weighted_lines_eval: table loads and samples are
// driven through the request channel while a bit-exact predictor computes
// each expected result and a monitor compares it field by field.
// ----------------------------------------------------------------------------
module tb;
   import gwle_pkg::*;

   localparam longint LIM46 = 64'sd1 << 46;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [4:0]    csr_wdata = '0;

   req_type       pending_items[$];
   rsp_type       expected_results[$];
   int            send_idle = 0;
   int            recv_idle = 0;
   bit            took = 1'b0;
   bit            hold_go = 1'b0;
   int            hold_cnt = 0;
   int            quiet_cycles = 0;
   int            errors = 0;

   // predictor state
   longint        exp_lut[EXP_ENTRIES];
   longint        centers[CEN_DEPTH];
   longint        inv_cov[COV_DEPTH];
   longint        slopes[CEN_DEPTH];
   longint        offsets[MAX_BASIS];
   longint        coords[MAX_DIMS];
   int            coords_held = 0;
   int            cfg_norm = 0;
   int            cfg_pivot = 0;
   int            cfg_basis = 16;
   int            cfg_dims = 1;

   gaussian_weighted_lines_eval dut (.*);

   always #6 clock = ~clock;

   function automatic longint sat46(longint v);
      if (v > LIM46) return LIM46;
      if (v < -LIM46) return -LIM46;
      return v;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint unsigned ua, ub, p;
      ua = magnitude(a);
      ub = magnitude(b);
      if (ua != 0 && ub > 64'hFFFF_FFFF_FFFF_FFFF / ua) p = LIM46;
      else begin
         p = (ua * ub) >> 16;
         if (p > LIM46) p = LIM46;
      end
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic void fill_exp_lut();
      longint unsigned term, pos, neg, r30, e30;
      term = 64'd1 << 58;
      pos = term;
      neg = 0;
      for (int n = 1; n <= 24; n++) begin
         term = term * 16 / (longint'(EXP_ENTRIES) * n);
         if (n % 2) neg += term;
         else pos += term;
      end
      r30 = (pos - neg) >> 28;
      e30 = 64'd1 << 30;
      for (int k = 0; k < EXP_ENTRIES; k++) begin
         exp_lut[k] = (e30 + 8192) >> 14;
         e30 = (e30 * r30) >> 30;
      end
   endfunction

   function automatic rsp_type weigh_lines();
      int nb, nd;
      longint acc, wsum, line0, res, q, t, line, w;
      longint diff[MAX_DIMS];
      longint unsigned idx, m;
      rsp_type r;
      nb = cfg_basis < 1 ? 1 : (cfg_basis > MAX_BASIS ? MAX_BASIS : cfg_basis);
      nd = cfg_dims < 1 ? 1 : (cfg_dims > MAX_DIMS ? MAX_DIMS : cfg_dims);
      acc = 0;
      wsum = 0;
      line0 = 0;
      r.zero_sum = 1'b0;
      for (int b = 0; b < nb; b++) begin
         q = 0;
         for (int i = 0; i < nd; i++) diff[i] = coords[i] - centers[b*MAX_DIMS+i];
         for (int i = 0; i < nd; i++) begin
            t = 0;
            for (int k = 0; k < nd; k++)
               t = sat46(t + qmul(inv_cov[(b*MAX_DIMS+i)*MAX_DIMS+k], diff[k]));
            q = sat46(q + qmul(diff[i], t));
         end
         if (q < 0) q = 0;
         idx = (longint'(q) * EXP_ENTRIES) >> 21;
         w = (idx >= EXP_ENTRIES) ? 0 : exp_lut[idx];
         line = offsets[b];
         for (int i = 0; i < nd; i++)
            line = sat46(line + qmul(slopes[b*MAX_DIMS+i], coords[i]));
         if (cfg_pivot)
            for (int i = 0; i < nd; i++)
               line = sat46(line - qmul(slopes[b*MAX_DIMS+i], centers[b*MAX_DIMS+i]));
         if (b == 0) line0 = line;
         acc = sat46(acc + qmul(line, w));
         wsum += w;
      end
      if (cfg_norm && nb == 1) res = line0;
      else if (cfg_norm) begin
         if (wsum == 0) begin
            res = 0;
            r.zero_sum = 1'b1;
         end else begin
            m = (magnitude(acc) << 16) / longint'(wsum);
            res = acc < 0 ? -longint'(m) : longint'(m);
         end
      end else res = acc;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      r.weighted_sum = res[31:0];
      return r;
   endfunction

   function automatic void apply_transfer(req_type it);
      longint word;
      int nd;
      word = longint'(it.word_value);
      if (it.mode == MODE_LOAD) begin
         case (region_type'(it.region))
            RGN_CENTER: if (it.entry_index < CEN_DEPTH) centers[it.entry_index] = word;
            RGN_COV:    if (it.entry_index < COV_DEPTH) inv_cov[it.entry_index] = word;
            RGN_SLOPE:  if (it.entry_index < CEN_DEPTH) slopes[it.entry_index] = word;
            RGN_OFFSET: if (it.entry_index < MAX_BASIS) offsets[it.entry_index] = word;
            default: ;
         endcase
         return;
      end
      nd = cfg_dims < 1 ? 1 : (cfg_dims > MAX_DIMS ? MAX_DIMS : cfg_dims);
      if (coords_held >= MAX_DIMS) coords_held = MAX_DIMS - 1;
      coords[coords_held] = word;
      coords_held++;
      if (coords_held < nd) return;
      coords_held = 0;
      expected_results.push_back(weigh_lines());
   endfunction

   function automatic logic signed [31:0] near_word();
      return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
   endfunction

   function automatic logic signed [31:0] any_word();
      case ($urandom_range(0, 3))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic void push_load(region_type rg, int idx, logic signed [31:0] v);
      req_type it;
      it.mode = MODE_LOAD;
      it.region = rg;
      it.entry_index = 6'(idx);
      it.word_value = v;
      pending_items.push_back(it);
   endfunction

   function automatic void push_coord(logic signed [31:0] v);
      req_type it;
      it.mode = MODE_SAMPLE;
      it.region = 2'($urandom);
      it.entry_index = 6'($urandom);
      it.word_value = v;
      pending_items.push_back(it);
   endfunction

   function automatic logic signed [31:0] cov_word(int idx);
      if ((idx / MAX_DIMS) % MAX_DIMS == idx % MAX_DIMS)
         return $urandom_range(16384, 65536);
      return $signed($urandom_range(0, 8192)) - 4096;
   endfunction

   task automatic write_csr(csr_index_type idx, int v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 5'(v);
      case (idx)
         CSR_NORMALIZE: cfg_norm = v & 1;
         CSR_PIVOT:     cfg_pivot = v & 1;
         CSR_BASIS:     cfg_basis = v & 31;
         CSR_DIMS:      cfg_dims = v & 3;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(int nrm, int piv, int nb, int nd);
      write_csr(CSR_NORMALIZE, nrm);
      write_csr(CSR_PIVOT, piv);
      write_csr(CSR_BASIS, nb);
      write_csr(CSR_DIMS, nd);
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || expected_results.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (req_valid && !took) begin
      end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
         req_valid <= 1'b1;
         req_data <= pending_items.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < recv_idle;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      took <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) apply_transfer(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result weighted_sum=%h zero_sum=%b",
                      rsp_data.weighted_sum, rsp_data.zero_sum);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.weighted_sum !== want.weighted_sum) begin
                  $error("weighted_sum expected %h actual %h",
                         want.weighted_sum, rsp_data.weighted_sum);
                  errors++;
               end
               if (rsp_data.zero_sum !== want.zero_sum) begin
                  $error("zero_sum expected %b actual %b", want.zero_sum, rsp_data.zero_sum);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("FAIL gaussian_weighted_lines_eval");
         $finish;
      end
   end

   initial begin
      int nrm[8] = '{0, 1, 1, 0, 1, 0, 1, 0};
      int piv[8] = '{0, 0, 1, 1, 0, 0, 1, 0};
      int nbs[8] = '{16, 1, 3, 0, 20, 2, 31, 5};
      int nds[8] = '{1, 2, 2, 0, 3, 2, 1, 2};
      int nd, kind;
      fill_exp_lut();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every table entry gets a defined value first
      for (int i = 0; i < CEN_DEPTH; i++) push_load(RGN_CENTER, i, near_word());
      for (int i = 0; i < COV_DEPTH; i++) push_load(RGN_COV, i, cov_word(i));
      for (int i = 0; i < CEN_DEPTH; i++) push_load(RGN_SLOPE, i, near_word());
      for (int i = 0; i < MAX_BASIS; i++) push_load(RGN_OFFSET, i, near_word());
      drain();

      // directed cases
      configure(1, 1, 2, 2);
      push_coord(32'sh0); push_coord(32'sh0);
      push_coord(32'sh7FFF_FFFF); push_coord(32'sh8000_0000);
      push_coord(32'sh8000_0000); push_coord(32'sh7FFF_FFFF);
      push_load(RGN_CENTER, 40, 32'sh7FFF_FFFF);
      push_load(RGN_OFFSET, 20, 32'sh8000_0000);
      push_load(RGN_COV, 63, 32'sh7FFF_FFFF);
      push_load(RGN_CENTER, 0, 32'sh0); push_load(RGN_CENTER, 1, 32'sh0);
      push_load(RGN_COV, 0, -32'sh0010_0000);
      push_coord(32'sh0001_0000); push_coord(32'sh0);
      push_coord(32'sh03E8_0000); push_coord(32'sh03E8_0000);
      push_load(RGN_COV, 0, 32'sh0001_0000);
      push_coord(32'sh0000_8000); push_coord(-32'sh0000_8000);
      drain();
      configure(1, 0, 1, 1);
      push_coord(32'sh0003_0000);
      push_coord(32'sh7FFF_FFFF);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 3) begin send_idle = 23; recv_idle = 67; end
         else if (ph < 6) begin send_idle = 67; recv_idle = 23; end
         else begin send_idle = 0; recv_idle = 0; end
         configure(nrm[ph], piv[ph], nbs[ph], nds[ph]);
         nd = nds[ph] < 1 ? 1 : (nds[ph] > MAX_DIMS ? MAX_DIMS : nds[ph]);
         for (int i = 0; i < 70; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) push_load(region_type'($urandom_range(0, 3)),
                                    $urandom_range(0, 15), near_word());
            else if (kind == 2) push_load(region_type'($urandom_range(0, 3)),
                                          $urandom_range(0, 63), any_word());
            else for (int d = 0; d < nd; d++)
               push_coord(kind == 3 ? any_word() : near_word());
         end
         if (ph == 6) hold_go = 1'b1;
         drain();
      end

      if (errors == 0) $display("PASS gaussian_weighted_lines_eval");
      else $display("FAIL gaussian_weighted_lines_eval");
      $finish;
   end

endmodule

// ===== sim.f =====
src/gwle_pkg.sv
src/gwle_tables.sv
src/gwle_mul.sv
src/gwle_div.sv
src/gaussian_weighted_lines_eval.sv
sim/tb.sv
